FILE: rtl/xyz_lab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyz_lab_pkg
// Shared types and constants for the XYZ to L*a*b* pipeline.
// ----------------------------------------------------------------------------
package xyz_lab_pkg;

  localparam int DIV_STEPS  = 61;   // quotient bits of n*2^45/d
  localparam int ROOT_STEPS = 21;   // root bits of a 63-bit radicand

  typedef enum logic [1:0] {
    REG_WHITE_X = 2'd0,
    REG_WHITE_Y = 2'd1,
    REG_WHITE_Z = 2'd2
  } reg_idx_t;

  // one channel of the restoring divider: cube lane and linear lane
  typedef struct packed {
    logic [15:0] d;
    logic        cube;
    logic [15:0] rq;
    logic [60:0] nq;
    logic [15:0] rl;
    logic [60:0] nl;
  } div_ch_t;

  typedef struct packed {
    logic               vld;
    div_ch_t [2:0]      ch;
  } div_t;

  // one channel of the digit-by-digit cube root
  typedef struct packed {
    logic        cube;
    logic [21:0] p;
    logic [47:0] rem;
    logic [20:0] r;
    logic [41:0] r2;
    logic [62:0] qs;
  } root_ch_t;

  typedef struct packed {
    logic               vld;
    root_ch_t [2:0]     ch;
  } root_t;

endpackage

FILE: rtl/xyz_lab_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyz_lab_div_cell
// One restoring-division step for all three channels, two lanes each.
// ----------------------------------------------------------------------------
module xyz_lab_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  xyz_lab_pkg::div_t st_i,
  output xyz_lab_pkg::div_t st_o
);
  import xyz_lab_pkg::*;

  div_t st_r;
  div_t st_nxt;

  always_comb begin
    logic [16:0] rem2q;
    logic [16:0] rem2l;
    st_nxt = st_i;
    for (int c = 0; c < 3; c++) begin
      rem2q = {st_i.ch[c].rq, st_i.ch[c].nq[60]};
      rem2l = {st_i.ch[c].rl, st_i.ch[c].nl[60]};
      if (rem2q >= {1'b0, st_i.ch[c].d}) begin
        st_nxt.ch[c].rq = 16'(rem2q - {1'b0, st_i.ch[c].d});
        st_nxt.ch[c].nq = {st_i.ch[c].nq[59:0], 1'b1};
      end else begin
        st_nxt.ch[c].rq = rem2q[15:0];
        st_nxt.ch[c].nq = {st_i.ch[c].nq[59:0], 1'b0};
      end
      if (rem2l >= {1'b0, st_i.ch[c].d}) begin
        st_nxt.ch[c].rl = 16'(rem2l - {1'b0, st_i.ch[c].d});
        st_nxt.ch[c].nl = {st_i.ch[c].nl[59:0], 1'b1};
      end else begin
        st_nxt.ch[c].rl = rem2l[15:0];
        st_nxt.ch[c].nl = {st_i.ch[c].nl[59:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

FILE: rtl/xyz_lab_root_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyz_lab_root_cell
// One cube-root digit step for all three channels (3 radicand bits in).
// ----------------------------------------------------------------------------
module xyz_lab_root_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  xyz_lab_pkg::root_t st_i,
  output xyz_lab_pkg::root_t st_o
);
  import xyz_lab_pkg::*;

  root_t st_r;
  root_t st_nxt;

  always_comb begin
    logic [47:0] rem8;
    logic [47:0] trial;
    st_nxt = st_i;
    for (int c = 0; c < 3; c++) begin
      rem8  = {st_i.ch[c].rem[44:0], st_i.ch[c].qs[62:60]};
      // (2r+1)^3 - 8r^3 = 12r^2 + 6r + 1
      trial = {3'b0, st_i.ch[c].r2, 3'b0} + {4'b0, st_i.ch[c].r2, 2'b0}
            + {25'b0, st_i.ch[c].r, 2'b0} + {26'b0, st_i.ch[c].r, 1'b0} + 48'd1;
      st_nxt.ch[c].qs = {st_i.ch[c].qs[59:0], 3'b0};
      if (rem8 >= trial) begin
        st_nxt.ch[c].rem = rem8 - trial;
        st_nxt.ch[c].r   = {st_i.ch[c].r[19:0], 1'b1};
        st_nxt.ch[c].r2  = {st_i.ch[c].r2[39:0], 2'b0}
                         + {19'b0, st_i.ch[c].r, 2'b0} + 42'd1;
      end else begin
        st_nxt.ch[c].rem = rem8;
        st_nxt.ch[c].r   = {st_i.ch[c].r[19:0], 1'b0};
        st_nxt.ch[c].r2  = {st_i.ch[c].r2[39:0], 2'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

FILE: rtl/xyz_to_lab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyz_to_lab
// CIE XYZ to L*a*b* converter, one pixel per cycle unless the output stalls, fully pipelined.
// ----------------------------------------------------------------------------
// channel | dir | fields (tdata, low bit first)
// in_*    | in  | x_in[15:0], y_in[15:0], z_in[15:0]
// out_*   | out | lightness[14:0], green_red[16:0], blue_yellow[16:0], pad 7
// cfg_*   | in  | cfg_addr selects white_x / white_y / white_z
//
// One pixel accepted per cycle unless the output stalls; the stages are the input stage, 61
// divider cells, 21 cube-root cells, reciprocal multiply, select and output register.
// The divider chain is the longest part: one quotient bit per cell.
// A stalled output freezes the whole pipeline; in_tready follows it.
// Synchronous reset clears the valid bits and loads the D65 white point.
// ----------------------------------------------------------------------------
module xyz_to_lab (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_in, y_in, z_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // lightness, green_red, blue_yellow, zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import xyz_lab_pkg::*;

  logic [15:0] white_r [3];
  logic        adv;

  div_t  div_s  [DIV_STEPS+1];
  root_t root_s [ROOT_STEPS+1];

  logic        f1_vld_r;
  logic        f1_cube_r [3];
  logic [20:0] f1_root_r [3];
  logic [44:0] f1_prod_r [3];
  logic        f2_vld_r;
  logic [20:0] f2_f_r    [3];

  logic        out_vld_r;
  logic [55:0] out_data_r;
  logic [55:0] out_data_nxt;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r[0] <= 16'd24332;
      white_r[1] <= 16'd25600;
      white_r[2] <= 16'd27874;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WHITE_X: white_r[0] <= cfg_wdata;
        REG_WHITE_Y: white_r[1] <= cfg_wdata;
        REG_WHITE_Z: white_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage: branch compare and numerators
  div_t s0_r;
  div_t s0_nxt;

  always_comb begin
    logic [15:0] n;
    logic [15:0] d;
    logic [28:0] m;
    s0_nxt.vld = in_tvalid;
    for (int c = 0; c < 3; c++) begin
      n = in_tdata[16*c +: 16];
      d = (white_r[c] == 16'd0) ? 16'd1 : white_r[c];
      m = {13'b0, n} * 29'd7787;
      s0_nxt.ch[c].d    = d;
      s0_nxt.ch[c].cube = ({20'b0, n} * 36'd1000000) > ({20'b0, d} * 36'd8856);
      s0_nxt.ch[c].rq   = '0;
      s0_nxt.ch[c].nq   = {n, 45'b0};
      s0_nxt.ch[c].rl   = '0;
      s0_nxt.ch[c].nl   = {17'b0, m, 15'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  assign div_s[0] = s0_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    xyz_lab_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .st_i (div_s[i]),
      .st_o (div_s[i+1])
    );
  end

  always_comb begin
    root_s[0].vld = div_s[DIV_STEPS].vld;
    for (int c = 0; c < 3; c++) begin
      root_s[0].ch[c].cube = div_s[DIV_STEPS].ch[c].cube;
      root_s[0].ch[c].p    = div_s[DIV_STEPS].ch[c].nl[21:0];
      root_s[0].ch[c].rem  = '0;
      root_s[0].ch[c].r    = '0;
      root_s[0].ch[c].r2   = '0;
      root_s[0].ch[c].qs   = {2'b0, div_s[DIV_STEPS].ch[c].nq};
    end
  end

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
    xyz_lab_root_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .st_i (root_s[i]),
      .st_o (root_s[i+1])
    );
  end

  // p/1000 via ceil(2^32/1000); exact while p < 2^22 (linear branch)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= root_s[ROOT_STEPS].vld;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        f1_cube_r[c] <= root_s[ROOT_STEPS].ch[c].cube;
        f1_root_r[c] <= root_s[ROOT_STEPS].ch[c].r;
        f1_prod_r[c] <= {23'b0, root_s[ROOT_STEPS].ch[c].p} * 45'd4294968;
        f2_f_r[c]    <= f1_cube_r[c] ? f1_root_r[c]
                                     : {8'b0, f1_prod_r[c][44:32]} + 21'd4520;
      end
    end
  end

  always_comb begin
    logic signed [22:0] l_t;
    logic signed [22:0] dxy;
    logic signed [22:0] dyz;
    logic signed [32:0] a_t;
    logic signed [32:0] b_t;
    logic [14:0]        l_o;
    logic [16:0]        a_o;
    logic [16:0]        b_o;
    l_t = 23'(({7'b0, f2_f_r[1]} * 28'd116 + 28'd64) >> 7) - 23'sd4096;
    if (l_t < 0)                  l_o = 15'd0;
    else if (l_t > 23'sd25600)    l_o = 15'd25600;
    else                          l_o = l_t[14:0];
    dxy = $signed({2'b0, f2_f_r[0]}) - $signed({2'b0, f2_f_r[1]});
    dyz = $signed({2'b0, f2_f_r[1]}) - $signed({2'b0, f2_f_r[2]});
    a_t = (33'(dxy) * 33'sd500 + 33'sd256) >>> 9;
    b_t = (33'(dyz) * 33'sd200 + 33'sd256) >>> 9;
    if (a_t < -33'sd65536)        a_o = 17'h10000;
    else if (a_t > 33'sd65535)    a_o = 17'h0FFFF;
    else                          a_o = a_t[16:0];
    if (b_t < -33'sd65536)        b_o = 17'h10000;
    else if (b_t > 33'sd65535)    b_o = 17'h0FFFF;
    else                          b_o = b_t[16:0];
    out_data_nxt = {7'b0, b_o, a_o, l_o};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/xyz_to_lab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyz_to_lab_checker
// Port-level checks for xyz_to_lab, bound to the top level.
// ----------------------------------------------------------------------------
module xyz_to_lab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output request changed while stalled");

  a_light: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:0] <= 15'd25600)
    else $error("lightness out of range");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:49] == 7'd0)
    else $error("tdata padding not zero");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not track output stall");

endmodule

bind xyz_to_lab xyz_to_lab_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
